// ----- design/wstc_pkg.sv -----
// Shared types, constants and the arctangent table of the waypoint controller
package wstc_pkg;

    // angle units are 2^-29 rad
    localparam logic signed [33:0] ANG_PI      = 34'sd1686629713;
    localparam logic signed [33:0] ANG_TWO_PI  = 34'sd3373259426;
    localparam logic signed [33:0] ANG_HALF_PI = 34'sd843314857;
    // inverse cordic gain in Q30
    localparam logic signed [63:0] CORDIC_K30  = 64'sd652032874;

    // configuration register indexes
    localparam logic [1:0] CFG_TARGET_SPEED = 2'd0;
    localparam logic [1:0] CFG_ARRIVE_TOL   = 2'd1;
    localparam logic [1:0] CFG_MAX_STEER    = 2'd2;
    localparam logic [1:0] CFG_WP_COUNT     = 2'd3;

    // item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic        [15:0] time_step;
        logic        [7:0]  entry_index;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] steering;
        logic        [15:0] throttle;
        logic               path_done;
        logic        [8:0]  goal_index;
    } out_item_t;

    typedef enum logic {
        CORDIC_VEC = 1'b0,
        CORDIC_ROT = 1'b1
    } cordic_mode_t;

    typedef struct packed {
        logic               start;
        cordic_mode_t       mode;
        logic signed [63:0] x0;
        logic signed [63:0] y0;
        logic signed [33:0] z0;
    } cordic_req_t;

    // atan(2^-i) in 2^-29 rad
    function automatic logic [31:0] atan_at(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd421657428;
            5'd1:    v = 32'd248918915;
            5'd2:    v = 32'd131521918;
            5'd3:    v = 32'd66762579;
            5'd4:    v = 32'd33510843;
            5'd5:    v = 32'd16771758;
            5'd6:    v = 32'd8387925;
            5'd7:    v = 32'd4194219;
            5'd8:    v = 32'd2097141;
            5'd9:    v = 32'd1048575;
            5'd10:   v = 32'd524288;
            5'd11:   v = 32'd262144;
            5'd12:   v = 32'd131072;
            5'd13:   v = 32'd65536;
            5'd14:   v = 32'd32768;
            5'd15:   v = 32'd16384;
            5'd16:   v = 32'd8192;
            5'd17:   v = 32'd4096;
            5'd18:   v = 32'd2048;
            5'd19:   v = 32'd1024;
            5'd20:   v = 32'd512;
            5'd21:   v = 32'd256;
            5'd22:   v = 32'd128;
            5'd23:   v = 32'd64;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/wstc_ram.sv -----
// Generic single write port, single read port RAM with registered read
module wstc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/wstc_sqrt.sv -----
// Digit-serial integer square root, two radicand bits per cycle
module wstc_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] radicand,
    output logic        done,
    output logic [23:0] root
);
    logic [47:0] rad_reg;
    logic [25:0] rem_reg;
    logic [23:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [27:0] cur;
    logic [27:0] trial;
    logic        fits;

    // one root digit per cycle
    assign cur   = {rem_reg, rad_reg[47:46]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = cur >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[45:0], 2'b00};
                rem_reg  <= fits ? 26'(cur - trial) : cur[25:0];
                root_reg <= {root_reg[22:0], fits};
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd23) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ----- design/wstc_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle
module wstc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [32:0] quotient
);
    logic [32:0] dvd_reg;
    logic [15:0] dvs_reg;
    logic [15:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] cur;
    logic        fits;

    // shift in one dividend bit and try a subtract
    assign cur  = {rem_reg, dvd_reg[32]};
    assign fits = cur >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= fits ? 16'(cur - {1'b0, dvs_reg}) : cur[15:0];
                dvd_reg <= {dvd_reg[31:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd32) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;
endmodule

// ----- design/wstc_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle, vectoring and rotation modes
module wstc_cordic #(
    parameter int STEPS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  wstc_pkg::cordic_req_t   req,
    output logic                    done,
    output logic signed [63:0]      x_out,
    output logic signed [33:0]      z_out
);
    import wstc_pkg::*;

    localparam int IW = $clog2(STEPS + 1);

    logic signed [63:0] x_reg;
    logic signed [63:0] y_reg;
    logic signed [33:0] z_reg;
    logic [IW-1:0]      iter_reg;
    cordic_mode_t       mode_reg;
    logic               zero_reg;
    logic               busy_reg;
    logic               done_reg;

    logic signed [63:0] sx;
    logic signed [63:0] sy;
    logic signed [33:0] atan_v;
    logic               plus;
    logic signed [63:0] px;
    logic signed [63:0] py;

    // shifted terms and rotation direction
    assign sx     = x_reg >>> iter_reg;
    assign sy     = y_reg >>> iter_reg;
    assign atan_v = {2'b00, atan_at(5'(iter_reg))};
    assign plus   = (mode_reg == CORDIC_VEC) ? (y_reg > 0) : (z_reg < 0);

    // prescaled vector for vectoring mode
    assign px = req.x0 <<< 24;
    assign py = req.y0 <<< 24;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
                mode_reg <= req.mode;
                if (req.mode == CORDIC_VEC) begin
                    zero_reg <= (req.x0 == 0) && (req.y0 == 0);
                    // fold the left half plane onto the right one
                    if (px < 0) begin
                        if (py >= 0) begin
                            x_reg <= py;
                            y_reg <= -px;
                            z_reg <= ANG_HALF_PI;
                        end else begin
                            x_reg <= -py;
                            y_reg <= px;
                            z_reg <= -ANG_HALF_PI;
                        end
                    end else begin
                        x_reg <= px;
                        y_reg <= py;
                        z_reg <= '0;
                    end
                end else begin
                    zero_reg <= 1'b0;
                    x_reg    <= req.x0;
                    y_reg    <= req.y0;
                    z_reg    <= req.z0;
                end
            end else if (busy_reg) begin
                if (plus) begin
                    x_reg <= x_reg + sy;
                    y_reg <= y_reg - sx;
                    z_reg <= z_reg + atan_v;
                end else begin
                    x_reg <= x_reg - sy;
                    y_reg <= y_reg + sx;
                    z_reg <= z_reg - atan_v;
                end
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == IW'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign z_out = zero_reg ? 34'sd0 : z_reg;
endmodule

// ----- design/waypoint_steer_throttle_controller_top.sv -----
// Waypoint following controller: sequencer, state and shared arithmetic units
// Writes are taken back to back; a tick with no waypoints or a first tick goes straight to
//   the final state, which raises its item once the output is free, and input then reopens.
// A full tick raises its item at the end of the state sequence; the serial root, the two
//   divisions (skipped when their divisor setting is zero) and the three CORDIC runs set its length.
// Reset (synchronous, active low) clears pointer, flags, time, last command; config to defaults.
module waypoint_steer_throttle_controller_top #(
    parameter int WAYPOINT_DEPTH = 256,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wstc_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wstc_pkg::out_item_t  m_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import wstc_pkg::*;

    localparam int AW = $clog2(WAYPOINT_DEPTH);

    typedef enum logic [23:0] {
        S_IDLE    = 24'h000001,
        S_SQVX    = 24'h000002,
        S_SQVY    = 24'h000004,
        S_SQRT_GO = 24'h000008,
        S_SQRT    = 24'h000010,
        S_DIVS_GO = 24'h000020,
        S_DIVS    = 24'h000040,
        S_YAW_GO  = 24'h000080,
        S_YAW     = 24'h000100,
        S_GOAL_GO = 24'h000200,
        S_GOAL    = 24'h000400,
        S_ERR     = 24'h000800,
        S_DIVE_GO = 24'h001000,
        S_DIVE    = 24'h002000,
        S_MANG    = 24'h004000,
        S_COS_GO  = 24'h008000,
        S_COS     = 24'h010000,
        S_MC2     = 24'h020000,
        S_THR     = 24'h040000,
        S_MAX     = 24'h080000,
        S_MAY     = 24'h100000,
        S_MTOL    = 24'h200000,
        S_ARRIVE  = 24'h400000,
        S_FIN     = 24'h800000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [14:0] target_speed_reg;
    logic [15:0] arrive_tol_reg;
    logic [13:0] max_steer_reg;
    logic [8:0]  wp_count_reg;

    // controller state
    logic [8:0]         goal_ptr_reg;
    logic               done_flag_reg;
    logic [31:0]        elapsed_reg;
    logic signed [15:0] last_steer_reg;
    logic [15:0]        last_thr_reg;

    // captured tick and intermediates
    logic signed [15:0] vx_reg;
    logic signed [15:0] vy_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic [23:0]        speed_reg;
    logic [16:0]        scale_reg;
    logic signed [33:0] yaw_reg;
    logic signed [33:0] goal_ang_reg;
    logic signed [33:0] err_reg;
    logic signed [32:0] c_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic               m_valid_reg;
    out_item_t          m_item_reg;

    // tick decode
    logic        s_fire;
    logic [8:0]  count;
    logic [8:0]  sel;
    logic [32:0] el_sum;
    logic [31:0] el_new;
    logic        out_free;

    // memory
    logic          ram_we;
    logic [63:0]   ram_rdata;

    // multiplier
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;

    // shared units
    cordic_req_t        cor_req;
    logic               cor_done;
    logic signed [63:0] cor_x;
    logic signed [33:0] cor_z;
    logic               sqrt_done;
    logic [23:0]        sqrt_root;
    logic               div_start;
    logic [32:0]        div_dividend;
    logic [15:0]        div_divisor;
    logic               div_done;
    logic [32:0]        div_quot;

    // datapath helpers
    logic signed [33:0] err_raw;
    logic signed [33:0] err_wrap;
    logic [32:0]        err_mag;
    logic [32:0]        adx;
    logic [32:0]        ady;
    logic               near;
    logic [63:0]        thr_sum;
    logic [19:0]        thr_q;
    logic [14:0]        steer_mag;
    logic [8:0]         gp_inc;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // active count and selected waypoint
    assign count  = (32'(wp_count_reg) < WAYPOINT_DEPTH) ? wp_count_reg : 9'(WAYPOINT_DEPTH);
    assign sel    = (goal_ptr_reg < count) ? goal_ptr_reg : 9'(count - 9'd1);
    assign el_sum = {1'b0, elapsed_reg} + {17'd0, s_item.time_step};
    assign el_new = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];

    assign ram_we = s_fire && (s_item.op == OP_WRITE)
                    && (32'(s_item.entry_index) < WAYPOINT_DEPTH);

    wstc_ram #(
        .WIDTH (64),
        .DEPTH (WAYPOINT_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(s_item.entry_index)),
        .wdata ({s_item.entry_x, s_item.entry_y}),
        .raddr (AW'(sel)),
        .rdata (ram_rdata)
    );

    // arrival magnitudes
    assign adx  = dx_reg[32] ? 33'(-dx_reg) : dx_reg;
    assign ady  = dy_reg[32] ? 33'(-dy_reg) : dy_reg;
    assign near = (adx < {17'd0, arrive_tol_reg}) && (ady < {17'd0, arrive_tol_reg});

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQVX: begin
                mul_a = 33'(vx_reg);
                mul_b = 33'(vx_reg);
            end
            S_SQVY: begin
                mul_a = 33'(vy_reg);
                mul_b = 33'(vy_reg);
            end
            S_MANG: begin
                mul_a = {16'd0, scale_reg};
                mul_b = ANG_PI[32:0];
            end
            S_MC2: begin
                mul_a = c_reg;
                mul_b = c_reg;
            end
            S_MAX: begin
                mul_a = {17'd0, adx[15:0]};
                mul_b = {17'd0, adx[15:0]};
            end
            S_MAY: begin
                mul_a = {17'd0, ady[15:0]};
                mul_b = {17'd0, ady[15:0]};
            end
            S_MTOL: begin
                mul_a = {17'd0, arrive_tol_reg};
                mul_b = {17'd0, arrive_tol_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // cordic requests
    always_comb begin
        cor_req.start = 1'b0;
        cor_req.mode  = CORDIC_VEC;
        cor_req.x0    = 64'(vx_reg);
        cor_req.y0    = 64'(vy_reg);
        cor_req.z0    = '0;
        case (state_reg)
            S_YAW_GO: begin
                cor_req.start = 1'b1;
            end
            S_GOAL_GO: begin
                cor_req.start = 1'b1;
                cor_req.x0    = 64'(dx_reg);
                cor_req.y0    = 64'(dy_reg);
            end
            S_COS_GO: begin
                cor_req.start = 1'b1;
                cor_req.mode  = CORDIC_ROT;
                cor_req.x0    = CORDIC_K30;
                cor_req.y0    = '0;
                cor_req.z0    = prod_reg[50:17];
            end
            default: begin
                cor_req.start = 1'b0;
            end
        endcase
    end

    wstc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cor_req),
        .done    (cor_done),
        .x_out   (cor_x),
        .z_out   (cor_z)
    );

    wstc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == S_SQRT_GO),
        .radicand ({acc_reg[31:0] + prod_reg[31:0], 16'd0}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // heading error wrapped to plus or minus pi
    assign err_raw  = goal_ang_reg - yaw_reg;
    assign err_wrap = (err_raw > ANG_PI) ? err_raw - ANG_TWO_PI :
                      (err_raw < -ANG_PI) ? err_raw + ANG_TWO_PI : err_raw;
    assign err_mag  = err_reg[33] ? 33'(-err_reg) : err_reg[32:0];

    // divider shared by speed ratio and steering
    always_comb begin
        if (state_reg == S_DIVE_GO) begin
            div_start    = (max_steer_reg != '0);
            div_dividend = err_mag;
            div_divisor  = {1'b0, max_steer_reg, 1'b0};
        end else begin
            div_start    = (state_reg == S_DIVS_GO) && (target_speed_reg != '0);
            div_dividend = {1'b0, speed_reg, 8'd0};
            div_divisor  = {1'b0, target_speed_reg};
        end
    end

    wstc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign steer_mag = (div_quot > 33'd32767) ? 15'd32767 : div_quot[14:0];
    assign thr_sum   = prod_reg + (64'sd1 <<< 43);
    assign thr_q     = thr_sum[63:44];
    assign gp_inc    = (near && (acc_reg < prod_reg) && (goal_ptr_reg < count))
                       ? goal_ptr_reg + 9'd1 : goal_ptr_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire && (s_item.op == OP_TICK)) begin
                    if ((count == '0) || (el_new <= {16'd0, s_item.time_step})) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_SQVX;
                    end
                end
            end
            S_SQVX:    state_next = S_SQVY;
            S_SQVY:    state_next = S_SQRT_GO;
            S_SQRT_GO: state_next = S_SQRT;
            S_SQRT:    if (sqrt_done) state_next = S_DIVS_GO;
            S_DIVS_GO: state_next = (target_speed_reg == '0) ? S_YAW_GO : S_DIVS;
            S_DIVS:    if (div_done) state_next = S_YAW_GO;
            S_YAW_GO:  state_next = S_YAW;
            S_YAW:     if (cor_done) state_next = S_GOAL_GO;
            S_GOAL_GO: state_next = S_GOAL;
            S_GOAL:    if (cor_done) state_next = S_ERR;
            S_ERR:     state_next = S_DIVE_GO;
            S_DIVE_GO: state_next = (max_steer_reg == '0) ? S_MANG : S_DIVE;
            S_DIVE:    if (div_done) state_next = S_MANG;
            S_MANG:    state_next = S_COS_GO;
            S_COS_GO:  state_next = S_COS;
            S_COS:     if (cor_done) state_next = S_MC2;
            S_MC2:     state_next = S_THR;
            S_THR:     state_next = S_MAX;
            S_MAX:     state_next = S_MAY;
            S_MAY:     state_next = S_MTOL;
            S_MTOL:    state_next = S_ARRIVE;
            S_ARRIVE:  state_next = S_FIN;
            S_FIN:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // control state, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            target_speed_reg <= 15'd512;
            arrive_tol_reg   <= 16'd256;
            max_steer_reg    <= 14'd1638;
            wp_count_reg     <= 9'd0;
            goal_ptr_reg     <= '0;
            done_flag_reg    <= 1'b0;
            elapsed_reg      <= '0;
            last_steer_reg   <= '0;
            last_thr_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_TARGET_SPEED: target_speed_reg <= cfg_data[14:0];
                    CFG_ARRIVE_TOL:   arrive_tol_reg   <= cfg_data;
                    CFG_MAX_STEER:    max_steer_reg    <= cfg_data[13:0];
                    CFG_WP_COUNT:     wp_count_reg     <= cfg_data[8:0];
                    default:          wp_count_reg     <= wp_count_reg;
                endcase
            end

            // tick entry
            if (s_fire && (s_item.op == OP_TICK)) begin
                if (count == '0) begin
                    done_flag_reg <= 1'b1;
                end else begin
                    elapsed_reg <= el_new;
                    if (el_new <= {16'd0, s_item.time_step}) begin
                        last_steer_reg <= '0;
                        last_thr_reg   <= '0;
                    end
                end
            end

            // steering
            if (state_reg == S_DIVE_GO && max_steer_reg == '0) begin
                last_steer_reg <= err_reg[33] ? -16'sd32767 :
                                  (err_reg != '0) ? 16'sd32767 : 16'sd0;
            end
            if (state_reg == S_DIVE && div_done) begin
                last_steer_reg <= err_reg[33] ? -$signed({1'b0, steer_mag})
                                              : $signed({1'b0, steer_mag});
            end

            // throttle
            if (state_reg == S_THR) begin
                last_thr_reg <= (thr_q > 20'd65535) ? 16'hFFFF : thr_q[15:0];
            end

            // arrival and pointer advance
            if (state_reg == S_ARRIVE) begin
                goal_ptr_reg <= gp_inc;
                if (gp_inc >= count) begin
                    done_flag_reg <= 1'b1;
                end
            end

            // output register
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p[63:0];
        if (s_fire) begin
            px_reg <= s_item.pos_x;
            py_reg <= s_item.pos_y;
            vx_reg <= s_item.vel_x;
            vy_reg <= s_item.vel_y;
        end
        if (state_reg == S_SQVX) begin
            dx_reg <= 33'($signed(ram_rdata[63:32])) - 33'(px_reg);
            dy_reg <= 33'($signed(ram_rdata[31:0])) - 33'(py_reg);
        end
        if (state_reg == S_SQVY || state_reg == S_MAY) begin
            acc_reg <= prod_reg;
        end
        if (state_reg == S_MTOL) begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (state_reg == S_SQRT && sqrt_done) begin
            speed_reg <= sqrt_root;
        end
        if (state_reg == S_DIVS_GO && target_speed_reg == '0) begin
            scale_reg <= 17'd65536;
        end
        if (state_reg == S_DIVS && div_done) begin
            scale_reg <= (div_quot > 33'd65536) ? 17'd65536 : div_quot[16:0];
        end
        if (state_reg == S_YAW && cor_done) begin
            yaw_reg <= cor_z;
        end
        if (state_reg == S_GOAL && cor_done) begin
            goal_ang_reg <= cor_z;
        end
        if (state_reg == S_ERR) begin
            err_reg <= err_wrap;
        end
        if (state_reg == S_COS && cor_done) begin
            c_reg <= cor_x[32:0];
        end
        if (state_reg == S_FIN && out_free) begin
            m_item_reg.steering   <= last_steer_reg;
            m_item_reg.throttle   <= last_thr_reg;
            m_item_reg.path_done  <= done_flag_reg;
            m_item_reg.goal_index <= goal_ptr_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // the path-done flag never clears outside reset
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        done_flag_reg |=> done_flag_reg)
        else $error("path done flag cleared");

    // a new item is only presented out of the final state
    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg && !m_ready)) |-> $past(state_reg == S_FIN))
        else $error("output loaded outside final state");

    // steering stays within plus or minus one
    a_steer_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_item_reg.steering != -16'sd32768))
        else $error("steering out of range");

    // no new item is taken while a tick is being worked
    a_one_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input taken during a tick");
endmodule

// ----- dv/tb_waypoint_steer_throttle_controller_top.sv -----
// Self-checking testbench for the waypoint steering and throttle controller
module tb_waypoint_steer_throttle_controller_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wstc_pkg::*;

    localparam int  DEPTH       = 256;
    localparam int  STEPS       = 16;
    localparam longint PI_ANG   = 64'sd1686629713;
    localparam longint HALF_ANG = 64'sd843314857;
    localparam longint K30      = 64'sd652032874;
    localparam longint ATAN_LUT [16] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758, 8387925,
        4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384};

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0]  cfg_index = CFG_TARGET_SPEED;
    logic [15:0] cfg_data = '0;

    waypoint_steer_throttle_controller_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // steering and throttle predictor with its queue of expected commands
    class steer_scoreboard;
        int unsigned  errors;
        out_item_t    cmd_q[$];
        logic signed [31:0] tab_x[DEPTH];
        logic signed [31:0] tab_y[DEPTH];
        bit [8:0]     goal_ptr;
        bit           done;
        bit [31:0]    elapsed;
        logic signed [15:0] hold_steer;
        bit [15:0]    hold_thr;
        bit [14:0]    tgt_speed;
        bit [15:0]    tol;
        bit [13:0]    steer_max;
        bit [8:0]     wp_count;

        function new();
            errors = 0; goal_ptr = 0; done = 0; elapsed = 0;
            hold_steer = 0; hold_thr = 0;
            tgt_speed = 512; tol = 256; steer_max = 1638; wp_count = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_TARGET_SPEED: tgt_speed = val[14:0];
                CFG_ARRIVE_TOL:   tol = val;
                CFG_MAX_STEER:    steer_max = val[13:0];
                CFG_WP_COUNT:     wp_count = val[8:0];
                default: ;
            endcase
        endfunction

        function int unsigned active_count();
            return (wp_count < DEPTH) ? wp_count : DEPTH;
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // vectoring rotations give the angle of (x, y)
        function longint heading(longint x, longint y);
            longint z, t, nx, ny;
            z = 0;
            if (x == 0 && y == 0) return 0;
            x = x * 64'sd16777216;
            y = y * 64'sd16777216;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = HALF_ANG;
                end else begin
                    x = -y; y = t; z = -HALF_ANG;
                end
            end
            for (int i = 0; i < STEPS; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_LUT[i];
                end else begin
                    nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_LUT[i];
                end
                x = nx; y = ny;
            end
            return z;
        endfunction

        function longint cosine(longint ang);
            longint x, y, z, nx, ny;
            x = K30; y = 0; z = ang;
            for (int i = 0; i < STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_LUT[i];
                end else begin
                    nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_LUT[i];
                end
                x = nx; y = ny;
            end
            return x;
        endfunction

        function void note_input(in_item_t it);
            int unsigned cnt, sel;
            longint vx, vy, dx, dy, err, steer, c;
            longint unsigned sq, speed, scale, c2, thr, adx, ady, tl, sum;
            out_item_t o;
            if (it.op == OP_WRITE) begin
                tab_x[it.entry_index] = it.entry_x;
                tab_y[it.entry_index] = it.entry_y;
                return;
            end
            cnt = active_count();
            if (cnt == 0) begin
                done = 1;
            end else begin
                elapsed = (elapsed > 32'hFFFF_FFFF - it.time_step) ? 32'hFFFF_FFFF
                                                                    : elapsed + it.time_step;
                if (elapsed <= it.time_step) begin
                    hold_steer = 0;
                    hold_thr = 0;
                end else begin
                    vx = it.vel_x;
                    vy = it.vel_y;
                    sq = vx * vx + vy * vy;
                    speed = root(sq << 16);
                    if (tgt_speed == 0) scale = 65536;
                    else begin
                        scale = speed * 256 / tgt_speed;
                        if (scale > 65536) scale = 65536;
                    end
                    sel = (goal_ptr < cnt) ? goal_ptr : cnt - 1;
                    dx = longint'(tab_x[sel]) - longint'(it.pos_x);
                    dy = longint'(tab_y[sel]) - longint'(it.pos_y);
                    err = heading(dx, dy) - heading(vx, vy);
                    if (err > PI_ANG) err -= 2 * PI_ANG;
                    else if (err < -PI_ANG) err += 2 * PI_ANG;
                    if (steer_max == 0) begin
                        steer = (err > 0) ? 32767 : ((err < 0) ? -32767 : 0);
                    end else begin
                        steer = err / (longint'(steer_max) * 2);
                        if (steer > 32767) steer = 32767;
                        if (steer < -32767) steer = -32767;
                    end
                    hold_steer = steer[15:0];
                    c = cosine(longint'((scale * longint'(PI_ANG)) >> 17));
                    c2 = c * c;
                    thr = (c2 + (64'd1 << 43)) >> 44;
                    hold_thr = (thr > 65535) ? 16'hFFFF : thr[15:0];
                    tl = tol;
                    adx = (dx < 0) ? -dx : dx;
                    ady = (dy < 0) ? -dy : dy;
                    sum = adx * adx + ady * ady;
                    if (adx < tl && ady < tl && sum < tl * tl && goal_ptr < cnt)
                        goal_ptr++;
                    if (goal_ptr >= cnt) done = 1;
                end
            end
            o.steering = hold_steer;
            o.throttle = hold_thr;
            o.path_done = done;
            o.goal_index = goal_ptr;
            cmd_q.insert(cmd_q.size(), o);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (cmd_q.size() == 0) begin
                $display("%0t unexpected command %p", $time, got);
                errors++;
                return;
            end
            want = cmd_q.pop_front();
            if (got.steering !== want.steering)
                $display("%0t steering exp %0d got %0d", $time, want.steering, got.steering);
            if (got.throttle !== want.throttle)
                $display("%0t throttle exp %0d got %0d", $time, want.throttle, got.throttle);
            if (got.path_done !== want.path_done)
                $display("%0t path_done exp %0b got %0b", $time, want.path_done, got.path_done);
            if (got.goal_index !== want.goal_index)
                $display("%0t goal_index exp %0d got %0d", $time, want.goal_index,
                         got.goal_index);
            if (got !== want) errors++;
        endfunction
    endclass

    steer_scoreboard sb = new();

    // stimulus-side copy of the table and which slots hold data
    logic signed [31:0] gen_x[DEPTH];
    logic signed [31:0] gen_y[DEPTH];
    bit                 slot_set[DEPTH];
    int  burst_left = 0;
    bit  no_idle = 0;
    bit  hold_req = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // monitor: accepted items feed the predictor, results are checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_item);
            if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
            if (m_valid && m_ready) sb.check_result(m_item);
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int run;
        bit lvl;
        forever begin
            if (hold_req) begin
                hold_req = 0;
                run = 2000;
                lvl = 0;
            end else if (no_idle) begin
                run = 8; lvl = 1;
            end else begin
                lvl = $urandom_range(0, 2) != 0;
                run = lvl ? $urandom_range(1, 40) : $urandom_range(1, 25);
            end
            repeat (run) begin
                @(posedge aclk);
                m_ready <= lvl;
            end
        end
    end

    task automatic send_item(in_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // lowers valid and waits until every command is back and the block is quiet
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.cmd_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_all(int ts, int tl, int ms, int cnt);
        cfg_write(CFG_TARGET_SPEED, 16'(ts));
        cfg_write(CFG_ARRIVE_TOL, 16'(tl));
        cfg_write(CFG_MAX_STEER, 16'(ms));
        cfg_write(CFG_WP_COUNT, 16'(cnt));
    endtask

    function automatic in_item_t mk_tick(logic signed [31:0] px, logic signed [31:0] py,
                                         logic signed [15:0] vx, logic signed [15:0] vy,
                                         logic [15:0] dt);
        in_item_t it;
        it.op = OP_TICK;
        it.pos_x = px; it.pos_y = py;
        it.vel_x = vx; it.vel_y = vy;
        it.time_step = dt;
        it.entry_index = 8'($urandom);
        it.entry_x = $urandom;
        it.entry_y = $urandom;
        return it;
    endfunction

    task automatic write_slot(logic [7:0] idx, logic signed [31:0] x, logic signed [31:0] y);
        in_item_t it;
        it = mk_tick($urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
        it.op = OP_WRITE;
        it.entry_index = idx;
        it.entry_x = x;
        it.entry_y = y;
        gen_x[idx] = x;
        gen_y[idx] = y;
        slot_set[idx] = 1;
        send_item(it);
    endtask

    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < DEPTH && slot_set[n]) n++;
        return n;
    endfunction

    // random tick, often placed near the current goal so that arrivals happen
    task automatic rand_tick();
        int unsigned cnt, sel, tl;
        logic signed [31:0] px, py, ox, oy;
        logic signed [15:0] vx, vy;
        logic [15:0] dt;
        cnt = sb.active_count();
        sel = (cnt == 0) ? 0 : ((sb.goal_ptr < cnt) ? sb.goal_ptr : cnt - 1);
        tl = sb.tol;
        ox = $urandom_range(0, 2 * tl + 2) - (tl + 1);
        oy = $urandom_range(0, 2 * tl + 2) - (tl + 1);
        if ($urandom_range(0, 9) < 6 && slot_set[sel]) begin
            px = gen_x[sel] - ox;
            py = gen_y[sel] - oy;
        end else begin
            px = $urandom;
            py = $urandom;
        end
        case ($urandom_range(0, 3))
            0: begin vx = 0; vy = 0; end
            1: begin
                vx = 16'($urandom_range(0, 2 * sb.tgt_speed) - sb.tgt_speed);
                vy = 16'($urandom_range(0, 2 * sb.tgt_speed) - sb.tgt_speed);
            end
            default: begin vx = 16'($urandom); vy = 16'($urandom); end
        endcase
        dt = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        send_item(mk_tick(px, py, vx, vy, dt));
    endtask

    initial begin
        int pre, cnt;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_all(512, 256, 1638, 0);

        // no waypoints: command held, path flagged done
        send_item(mk_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF, 16'sh8000, 16'hFFFF));
        send_item(mk_tick(0, 0, 0, 0, 0));
        write_slot(0, 0, 0);
        write_slot(1, 32'sh7FFF_FFFF, 32'sh8000_0000);
        write_slot(2, 32'sh8000_0000, 32'sh7FFF_FFFF);
        write_slot(3, 1000, -1000);
        drain();
        cfg_write(CFG_WP_COUNT, 4);
        // first tick with zero dt, then zero dt again, then the real first tick
        send_item(mk_tick(100, 100, 256, 0, 0));
        send_item(mk_tick(100, 100, 256, 0, 0));
        send_item(mk_tick(100, 100, 256, 0, 16'hFFFF));
        // zero velocity, then zero goal vector and arrival at slot 0
        send_item(mk_tick(5000, -3000, 0, 0, 20));
        send_item(mk_tick(0, 0, -256, 256, 20));
        send_item(mk_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000, 16'sh8000, 20));
        send_item(mk_tick(32'sh7FFF_FF00, 32'sh8000_0100, 16'sh7FFF, 16'sh7FFF, 20));
        send_item(mk_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh0001, 16'shFFFF, 20));
        send_item(mk_tick(1100, -1100, -512, -512, 20));
        // pointer still at slot 1, so slot 3 under this tick is not the goal
        send_item(mk_tick(1000, -1000, 512, 0, 20));
        drain();
        set_all(1, 65535, 1, 4);
        send_item(mk_tick(0, 0, 1, 1, 10));
        send_item(mk_tick(-5000, 9000, 16'sh8000, 0, 10));
        drain();
        set_all(32767, 0, 16383, 4);
        send_item(mk_tick(1000, -1000, 16'sh7FFF, 16'sh8000, 10));
        send_item(mk_tick(9, 9, 300, -300, 10));
        drain();
        // zero target speed and zero max steer
        set_all(0, 300, 0, 4);
        send_item(mk_tick(1000, -1000, 256, 256, 10));
        send_item(mk_tick(-7000, 4000, -300, 0, 10));
        send_item(mk_tick(1000, -1000, 0, 0, 10));
        drain();

        // fill the whole table, then run at the largest count
        for (int i = 0; i < DEPTH; i++) write_slot(8'(i), $urandom, $urandom);
        drain();
        set_all(512, 2048, 1638, DEPTH);
        no_idle = 1;
        repeat (40) rand_tick();
        no_idle = 0;
        drain();

        // random phases over varied settings
        for (int ph = 0; ph < 6; ph++) begin
            pre = written_prefix();
            cnt = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, pre);
            set_all($urandom_range(1, 3) == 1 ? $urandom_range(1, 32767) : $urandom_range(64, 1024),
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 4096),
                    $urandom_range(1, 16383), cnt);
            for (int k = 0; k < 110; k++) begin
                if (ph == 2 && k == 20) hold_req = 1;
                if (ph == 4 && k == 55) drain();
                if ($urandom_range(0, 4) == 0) write_slot(8'($urandom), $urandom, $urandom);
                else rand_tick();
            end
            drain();
        end

        if (sb.errors == 0 && sb.cmd_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(30_000_000);
        $display("status: fail");
        $finish;
    end
endmodule
